>>> rtl/mrdc_pkg.sv
// Shared types, constants and the remainder helper function of the mesh route direction block.
package mrdc_pkg;

  // Field widths
  localparam int COORD_BITS_DEF = 8;
  localparam int KIND_W         = 3;
  localparam int STEP_W         = 8;
  localparam int RADIUS_W       = 8;
  localparam int AREA_W         = 8;
  localparam int MASK_W         = 5;
  localparam int CFG_IDX_W      = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 2'd1;

  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

  // Routing kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_XFIRST    = 3'd0,
    KIND_YFIRST    = 3'd1,
    KIND_CW        = 3'd2,
    KIND_CW_OFFSET = 3'd3,
    KIND_RADIUS    = 3'd4,
    KIND_INDIV     = 3'd5,
    KIND_AREA      = 3'd6,
    KIND_NONE      = 3'd7
  } kind_e;

  // Quadrant of the offset; QUAD_L is the local node itself
  typedef enum logic [2:0] {
    QUAD_A,
    QUAD_B,
    QUAD_C,
    QUAD_D,
    QUAD_L
  } quad_e;

  typedef logic [MASK_W-1:0] dir_mask_t;

  localparam dir_mask_t DIR_L     = 5'b00001;
  localparam dir_mask_t DIR_N     = 5'b00010;
  localparam dir_mask_t DIR_E     = 5'b00100;
  localparam dir_mask_t DIR_S     = 5'b01000;
  localparam dir_mask_t DIR_W     = 5'b10000;
  localparam dir_mask_t DIR_NEIGH = 5'b11110;
  localparam dir_mask_t DIR_NONE  = 5'b00000;

  // Route decision handed to the remainder pipeline
  typedef struct packed {
    dir_mask_t mask;       // directions settled at decode time
    logic      add_local;  // local copy wanted if both remainders are zero
  } route_t;

  // One restoring step of a remainder: shift in one dividend bit, subtract if it fits
  function automatic logic [STEP_W-1:0] rem_step(input logic [STEP_W-1:0] rem,
                                                 input logic              dbit,
                                                 input logic [STEP_W-1:0] div);
    logic [STEP_W:0] trial;
    trial = {rem, dbit};
    if (trial >= {1'b0, div}) begin
      trial = trial - {1'b0, div};
    end
    return trial[STEP_W-1:0];
  endfunction

endpackage

>>> rtl/mesh_route_direction_compute.sv
// Top level: pipelined output-port selection of a 2D mesh router.
// A header passes through the input register, the decode stage and the remainder stages to the result.
// Throughput: one header per cycle while the output does not stall; two dividend bits per stage.
// Every stage holds its item under output stall and fills bubbles independently.
// Reset clears all valid bits and sets both step registers to one.
module mesh_route_direction_compute import mrdc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // header channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KIND_W-1:0]     req_type_i,
  input  logic [COORD_BITS-1:0] dx_i,
  input  logic [COORD_BITS-1:0] dy_i,
  input  logic [COORD_BITS-1:0] orig_x_i,
  input  logic [COORD_BITS-1:0] orig_y_i,
  input  logic [RADIUS_W-1:0]   hop_radius_i,
  input  logic [AREA_W-1:0]     area_x_i,
  input  logic [AREA_W-1:0]     area_y_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MASK_W-1:0]     dir_mask_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [STEP_W-1:0]     cfg_data_i
);

  localparam int DIV_STAGES = (COORD_BITS + 1) / 2;
  localparam int QW         = 2 * DIV_STAGES;
  localparam int NS         = DIV_STAGES + 1;

  // Configuration
  logic [STEP_W-1:0] step_x_q, step_y_q, step_x_eff, step_y_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q <= STEP_ONE;
      step_y_q <= STEP_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_STEP_X: step_x_q <= cfg_data_i;
        REG_STEP_Y: step_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a zero step means every node takes a copy
  assign step_x_eff = (step_x_q == '0) ? STEP_ONE : step_x_q;
  assign step_y_eff = (step_y_q == '0) ? STEP_ONE : step_y_q;

  // Input register stage
  logic                  s0_vld_q, s0_rdy;
  logic [KIND_W-1:0]     s0_kind_q;
  logic [COORD_BITS-1:0] s0_x_q, s0_y_q, s0_ox_q, s0_oy_q;
  logic [RADIUS_W-1:0]   s0_hops_q;
  logic [AREA_W-1:0]     s0_ax_q, s0_ay_q;

  // Decode and remainder stages 1..NS
  logic [NS:1]       vld_q, vld_d;
  logic [NS+1:1]     rdy;
  dir_mask_t         mask_q [NS:1];
  dir_mask_t         mask_d [NS:1];
  logic              addl_q [NS:1];
  logic              addl_d [NS:1];
  logic [QW-1:0]     divx_q [NS:1];
  logic [QW-1:0]     divx_d [NS:1];
  logic [QW-1:0]     divy_q [NS:1];
  logic [QW-1:0]     divy_d [NS:1];
  logic [STEP_W-1:0] remx_q [NS:1];
  logic [STEP_W-1:0] remx_d [NS:1];
  logic [STEP_W-1:0] remy_q [NS:1];
  logic [STEP_W-1:0] remy_d [NS:1];

  logic [COORD_BITS-1:0] abs_x, abs_y;
  route_t                route;

  // Ready chain: a stage loads when empty or when its content moves on
  always_comb begin
    rdy[NS+1] = !out_stall_i;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s0_rdy     = !s0_vld_q || rdy[1];
  assign in_stall_o = !s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy && in_valid_i) begin
      s0_kind_q <= req_type_i;
      s0_x_q    <= dx_i;
      s0_y_q    <= dy_i;
      s0_ox_q   <= orig_x_i;
      s0_oy_q   <= orig_y_i;
      s0_hops_q <= hop_radius_i;
      s0_ax_q   <= area_x_i;
      s0_ay_q   <= area_y_i;
    end
  end

  // Direction decode
  mrdc_route #(
    .COORD_BITS (COORD_BITS)
  ) u_route (
    .kind_i   (kind_e'(s0_kind_q)),
    .x_i      (s0_x_q),
    .y_i      (s0_y_q),
    .ox_i     (s0_ox_q),
    .oy_i     (s0_oy_q),
    .hops_i   (s0_hops_q),
    .area_x_i (s0_ax_q),
    .area_y_i (s0_ay_q),
    .abs_x_o  (abs_x),
    .abs_y_o  (abs_y),
    .route_o  (route)
  );

  // Next values: stage 1 takes the decode, later stages run two remainder steps each
  always_comb begin
    vld_d[1]  = s0_vld_q;
    mask_d[1] = route.mask;
    addl_d[1] = route.add_local;
    divx_d[1] = QW'(abs_x);
    divy_d[1] = QW'(abs_y);
    remx_d[1] = '0;
    remy_d[1] = '0;
    for (int k = 2; k <= NS; k++) begin
      vld_d[k]  = vld_q[k-1];
      mask_d[k] = mask_q[k-1];
      addl_d[k] = addl_q[k-1];
      remx_d[k] = rem_step(rem_step(remx_q[k-1], divx_q[k-1][QW-1], step_x_eff),
                           divx_q[k-1][QW-2], step_x_eff);
      remy_d[k] = rem_step(rem_step(remy_q[k-1], divy_q[k-1][QW-1], step_y_eff),
                           divy_q[k-1][QW-2], step_y_eff);
      divx_d[k] = divx_q[k-1] << 2;
      divy_d[k] = divy_q[k-1] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k] && vld_d[k]) begin
        mask_q[k] <= mask_d[k];
        addl_q[k] <= addl_d[k];
        divx_q[k] <= divx_d[k];
        divy_q[k] <= divy_d[k];
        remx_q[k] <= remx_d[k];
        remy_q[k] <= remy_d[k];
      end
    end
  end

  // Result: for individual multicast, the local copy is added only where both offsets are multiples of the steps
  assign out_valid_o = vld_q[NS];
  assign dir_mask_o  = mask_q[NS] |
                       ((addl_q[NS] && (remx_q[NS] == '0) && (remy_q[NS] == '0)) ?
                        DIR_L : DIR_NONE);

endmodule

>>> rtl/mrdc_route.sv
// Direction decode of one header for all routing kinds, plus offset magnitudes.
module mrdc_route import mrdc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  kind_e                  kind_i,
  input  logic [COORD_BITS-1:0]  x_i,
  input  logic [COORD_BITS-1:0]  y_i,
  input  logic [COORD_BITS-1:0]  ox_i,
  input  logic [COORD_BITS-1:0]  oy_i,
  input  logic [RADIUS_W-1:0]    hops_i,
  input  logic [AREA_W-1:0]      area_x_i,
  input  logic [AREA_W-1:0]      area_y_i,
  output logic [COORD_BITS-1:0]  abs_x_o,
  output logic [COORD_BITS-1:0]  abs_y_o,
  output route_t                 route_o
);

  // Compare width: holds |x|+|y| and the radius / area limits
  localparam int LIM_W = (RADIUS_W > AREA_W) ? RADIUS_W : AREA_W;
  localparam int CMP_W = (COORD_BITS + 1 > LIM_W) ? COORD_BITS + 1 : LIM_W;

  localparam logic [COORD_BITS-1:0] C_ONE       = COORD_BITS'(1);
  localparam logic [COORD_BITS-1:0] C_MINUS_ONE = '1;

  logic xz, yz, xneg, yneg, xpos, ypos;
  logic [CMP_W-1:0] sum_abs;
  logic radius_ok, in_x, in_y, at_origin;
  quad_e quad, quad_off;

  // Spread into the quadrant, shared by radius and individual multicast
  function automatic dir_mask_t spread(input dir_mask_t dir, input quad_e q,
                                       input logic x_zero, input logic y_zero);
    dir_mask_t res;
    res = dir;
    case (q)
      QUAD_A: begin
        res = res | DIR_E;
        if (x_zero) res = res | DIR_N;
      end
      QUAD_B: begin
        res = res | DIR_N;
        if (y_zero) res = res | DIR_W;
      end
      QUAD_C: begin
        res = res | DIR_W;
        if (x_zero) res = res | DIR_S;
      end
      QUAD_D: begin
        res = res | DIR_S;
        if (y_zero) res = res | DIR_E;
      end
      default: res = DIR_NEIGH;
    endcase
    return res;
  endfunction

  // Sign flags and magnitudes
  assign xz   = (x_i == '0);
  assign yz   = (y_i == '0);
  assign xneg = x_i[COORD_BITS-1];
  assign yneg = y_i[COORD_BITS-1];
  assign xpos = !xneg && !xz;
  assign ypos = !yneg && !yz;

  assign abs_x_o = xneg ? (~x_i + C_ONE) : x_i;
  assign abs_y_o = yneg ? (~y_i + C_ONE) : y_i;

  assign sum_abs   = CMP_W'(abs_x_o) + CMP_W'(abs_y_o);
  assign radius_ok = (hops_i == '0) || (sum_abs < CMP_W'(hops_i));
  assign in_x      = CMP_W'(abs_x_o) < CMP_W'(area_x_i);
  assign in_y      = CMP_W'(abs_y_o) < CMP_W'(area_y_i);
  assign at_origin = (ox_i == '0) && (oy_i == '0);

  // Quadrant classification
  always_comb begin
    if (!xneg && ypos)      quad = QUAD_A;
    else if (xneg && !yneg) quad = QUAD_B;
    else if (!xpos && yneg) quad = QUAD_C;
    else if (xpos && !ypos) quad = QUAD_D;
    else                    quad = QUAD_L;
  end

  // On-axis offsets are turned one quadrant on for the offset clockwise mode
  always_comb begin
    quad_off = quad;
    if (yz != xz) begin
      if (yz) begin
        if (quad == QUAD_D)      quad_off = QUAD_A;
        else if (quad == QUAD_B) quad_off = QUAD_C;
      end else begin
        if (quad == QUAD_C)      quad_off = QUAD_D;
        else if (quad == QUAD_A) quad_off = QUAD_B;
      end
    end
  end

  // Per-kind direction selection
  always_comb begin
    route_o.mask      = DIR_NONE;
    route_o.add_local = 1'b0;
    case (kind_i)
      KIND_XFIRST: begin
        if (xpos)      route_o.mask = DIR_E;
        else if (xneg) route_o.mask = DIR_W;
        else if (ypos) route_o.mask = DIR_N;
        else if (yneg) route_o.mask = DIR_S;
        else           route_o.mask = DIR_L;
      end
      KIND_YFIRST: begin
        if (ypos)      route_o.mask = DIR_N;
        else if (yneg) route_o.mask = DIR_S;
        else if (xpos) route_o.mask = DIR_E;
        else if (xneg) route_o.mask = DIR_W;
        else           route_o.mask = DIR_L;
      end
      KIND_CW: begin
        case (quad)
          QUAD_A:  route_o.mask = xz ? DIR_N : DIR_E;
          QUAD_B:  route_o.mask = yz ? DIR_W : DIR_N;
          QUAD_C:  route_o.mask = xz ? DIR_S : DIR_W;
          QUAD_D:  route_o.mask = yz ? DIR_E : DIR_S;
          default: route_o.mask = DIR_L;
        endcase
      end
      KIND_CW_OFFSET: begin
        case (quad_off)
          QUAD_A:  route_o.mask = ((x_i == C_ONE && !yz) || at_origin) ? DIR_N : DIR_E;
          QUAD_B:  route_o.mask = ((y_i == C_ONE && !xz) || at_origin) ? DIR_W : DIR_N;
          QUAD_C:  route_o.mask = ((x_i == C_MINUS_ONE && !yz) || at_origin) ? DIR_S : DIR_W;
          QUAD_D:  route_o.mask = ((y_i == C_MINUS_ONE && !xz) || at_origin) ? DIR_E : DIR_S;
          default: route_o.mask = DIR_L;
        endcase
      end
      KIND_RADIUS: begin
        route_o.mask = radius_ok ? spread(DIR_L, quad, xz, yz) : DIR_L;
      end
      KIND_INDIV: begin
        // local bit settled later by the step remainders
        route_o.mask      = spread(DIR_NONE, quad, xz, yz);
        route_o.add_local = (quad != QUAD_L);
      end
      KIND_AREA: begin
        route_o.mask = DIR_L;
        if (in_x || in_y) begin
          case (quad)
            QUAD_A: begin
              if (in_x)       route_o.mask = route_o.mask | DIR_E;
              if (xz && in_y) route_o.mask = route_o.mask | DIR_N;
            end
            QUAD_B: begin
              if (in_y)       route_o.mask = route_o.mask | DIR_N;
              if (yz && in_x) route_o.mask = route_o.mask | DIR_W;
            end
            QUAD_C: begin
              if (in_x)       route_o.mask = route_o.mask | DIR_W;
              if (xz && in_y) route_o.mask = route_o.mask | DIR_S;
            end
            QUAD_D: begin
              if (in_y)       route_o.mask = route_o.mask | DIR_S;
              if (yz && in_x) route_o.mask = route_o.mask | DIR_E;
            end
            default: route_o.mask = DIR_NEIGH;
          endcase
        end
      end
      default: route_o.mask = DIR_NONE;
    endcase
  end

endmodule
